>>> rtl/triangle_plane_setup_assert.svh
// ----------------------------------------------------------------------------
// Triangle plane setup assertion macros
// Shared property forms for the checker of the plane setup block.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_PLANE_SETUP_ASSERT_SVH
`define TRIANGLE_PLANE_SETUP_ASSERT_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define TPS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plane setup check failed");

// Condition in this cycle implies a consequence in the next cycle.
`define TPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plane setup check failed");

`endif

>>> rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// Triangle plane setup package
// Fixed widths of the normalization, square root and divide datapath.
// ----------------------------------------------------------------------------
package tps_pkg;

  // The largest normalized cross magnitude carries its leading one at bit MAG_BITS-1.
  localparam int MAG_BITS  = 30;
  // Sum of three squared magnitudes.
  localparam int SUM_BITS  = 2 * MAG_BITS + 2;
  // Integer square root of that sum.
  localparam int ROOT_BITS = SUM_BITS / 2;

endpackage

>>> rtl/triangle_plane_setup.sv
// ----------------------------------------------------------------------------
// Triangle plane setup
// Takes the three vertices of a collision triangle as signed fixed point
// words and returns the unit normal of the cross product (b - a) x (c - b)
// in Q1.NORMAL_FRAC_BITS, the plane offset -(n . a) rounded to the vertex
// format and saturated, and the least and greatest y of the vertices. A
// triangle whose cross product is zero returns the degenerate flag with all
// other fields zero. The block is a fully pipelined datapath: a new triangle
// word is taken every cycle while the pipeline is not frozen, and its result
// passes through the one-bit-per-stage square root (31 stages) and the
// one-bit-per-stage normal divider (NORMAL_FRAC_BITS + 3 stages). When the
// output word is held by out_stall, the whole pipeline freezes and in_stall
// is raised with it; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module triangle_plane_setup #(
  parameter int COORD_BITS       = 24,
  parameter int NORMAL_FRAC_BITS = 30
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] az,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] bz,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [COORD_BITS-1:0] cz,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           norm_x,
  output logic signed [31:0]           norm_y,
  output logic signed [31:0]           norm_z,
  output logic signed [COORD_BITS:0]   plane_offset,
  output logic signed [COORD_BITS-1:0] lowest_y,
  output logic signed [COORD_BITS-1:0] highest_y,
  output logic                         degenerate
);
  import tps_pkg::*;

  // Edge width; very wide coordinates are pre-shifted so that the edge
  // products stay within one multiplier each.
  localparam int EW     = (COORD_BITS + 1 > 31) ? 31 : COORD_BITS + 1;
  localparam int PRE    = (COORD_BITS + 1 > 31) ? COORD_BITS - 30 : 0;
  localparam int PW     = 2 * EW;
  localparam int CW     = 2 * EW + 1;
  localparam int MW     = (2 * EW > MAG_BITS) ? 2 * EW : MAG_BITS;
  localparam int LZW    = $clog2(MW);
  localparam int GROUPS = (MW + 7) / 8;
  localparam int GW     = GROUPS * 8;
  localparam int QB     = NORMAL_FRAC_BITS + 2;
  localparam int DPW    = QB + COORD_BITS;
  localparam int DOTW   = QB + COORD_BITS + 3;
  localparam int DIVLAT = QB + 1;

  localparam logic signed [DOTW-1:0] ROUND_HALF =
    {{(DOTW - NORMAL_FRAC_BITS){1'b0}}, 1'b1, {(NORMAL_FRAC_BITS - 1){1'b0}}};
  localparam logic signed [DOTW-1:0] OFF_MAX =
    {{(DOTW - COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
  localparam logic signed [DOTW-1:0] OFF_MIN = ~OFF_MAX;

  // Fields that ride alongside the arithmetic. The signs and the degenerate
  // flag are filled in once the cross product is known.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] ymin;
    logic signed [COORD_BITS-1:0] ymax;
    logic [2:0]                   sgn;
    logic                         degen;
  } side_t;

  typedef struct packed {
    side_t                      sb;
    logic [2:0][MAG_BITS-1:0]   nm;
  } mid_t;

  // The pipeline advances unless the output word is held.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  function automatic logic signed [EW-1:0] edge_diff(
    input logic signed [COORD_BITS-1:0] hi_v,
    input logic signed [COORD_BITS-1:0] lo_v
  );
    logic signed [COORD_BITS:0] d;
    logic signed [COORD_BITS:0] s;
    d = {hi_v[COORD_BITS-1], hi_v} - {lo_v[COORD_BITS-1], lo_v};
    s = d >>> PRE;
    return s[EW-1:0];
  endfunction

  function automatic logic [2:0] byte_lz(input logic [7:0] b);
    logic [2:0] n;
    logic       done;
    n    = '0;
    done = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!done) begin
        if (b[i]) begin
          done = 1'b1;
        end else begin
          n = n + 3'd1;
        end
      end
    end
    return n;
  endfunction

  // Valid bits of the front and back stages.
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13;
  logic mid_v [ROOT_BITS];
  logic sd_v  [DIVLAT];

  // Stage 1: edges and y bounds.
  side_t                side1_next, sb1;
  logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;

  always_comb begin
    side1_next       = '0;
    side1_next.ax    = ax;
    side1_next.ay    = ay;
    side1_next.az    = az;
    side1_next.ymin  = ay;
    side1_next.ymax  = ay;
    if (by < side1_next.ymin) side1_next.ymin = by;
    if (cy < side1_next.ymin) side1_next.ymin = cy;
    if (by > side1_next.ymax) side1_next.ymax = by;
    if (cy > side1_next.ymax) side1_next.ymax = cy;
  end

  // Stage 2: edge products p_yz to p_yx, on separate multipliers.
  side_t                sb2;
  logic signed [PW-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;

  // Stage 3: cross product.
  side_t                sb3;
  logic signed [CW-1:0] crx, cry, crz;

  // Stage 4: magnitudes, signs and the zero test.
  side_t              side4_next, sb4;
  logic [2:0][MW-1:0] mg_next, mg4;

  always_comb begin
    logic [CW-1:0] ab [3];
    ab[0] = crx[CW-1] ? CW'(-crx) : CW'(crx);
    ab[1] = cry[CW-1] ? CW'(-cry) : CW'(cry);
    ab[2] = crz[CW-1] ? CW'(-crz) : CW'(crz);
    for (int i = 0; i < 3; i++) begin
      mg_next[i] = MW'(ab[i]);
    end
    side4_next       = sb3;
    side4_next.sgn   = {crz[CW-1], cry[CW-1], crx[CW-1]};
    side4_next.degen = (crx == '0) && (cry == '0) && (crz == '0);
  end

  // Stage 5: largest magnitude.
  side_t              sb5;
  logic [2:0][MW-1:0] mg5;
  logic [MW-1:0]      mx_next, mx5;

  always_comb begin
    mx_next = mg4[0];
    if (mg4[1] > mx_next) mx_next = mg4[1];
    if (mg4[2] > mx_next) mx_next = mg4[2];
  end

  // Stage 6: per-byte leading zero counts of the largest magnitude,
  // left-aligned in whole bytes.
  side_t                   sb6;
  logic [2:0][MW-1:0]      mg6;
  logic [GROUPS-1:0]       gnz_next, gnz6;
  logic [GROUPS-1:0][2:0]  glz_next, glz6;

  always_comb begin
    logic [GW-1:0] mxp;
    mxp = GW'(mx5);
    mxp = mxp << (GW - MW);
    for (int g = 0; g < GROUPS; g++) begin
      gnz_next[g] = |mxp[g*8 +: 8];
      glz_next[g] = byte_lz(mxp[g*8 +: 8]);
    end
  end

  // Stage 7: leading zero count of the largest magnitude.
  side_t              sb7;
  logic [2:0][MW-1:0] mg7;
  logic [LZW-1:0]     lz_next, lz7;

  always_comb begin
    logic found;
    found   = 1'b0;
    lz_next = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (!found && gnz6[g]) begin
        found   = 1'b1;
        lz_next = LZW'((GROUPS - 1 - g) * 8) + LZW'(glz6[g]);
      end
    end
  end

  // Stage 8: common shift that puts the leading one at the top of MAG_BITS.
  side_t                    sb8;
  logic [2:0][MAG_BITS-1:0] nm_next, nm8;

  always_comb begin
    logic [MW-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      sh         = mg7[i] << lz7;
      nm_next[i] = sh[MW-1 -: MAG_BITS];
    end
  end

  // Stage 9: squares. Stage 10: their sum.
  side_t                      sb9;
  logic [2:0][MAG_BITS-1:0]   nm9;
  logic [2:0][2*MAG_BITS-1:0] sq9;
  mid_t                       mid10;
  logic [SUM_BITS-1:0]        sum10;

  // Square root, with the side fields and magnitudes delayed alongside.
  logic [ROOT_BITS-1:0] len_root;
  mid_t                 mid_q [ROOT_BITS];

  tps_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sum10),
    .root     (len_root)
  );

  // Normal divider, with the side fields delayed alongside.
  logic [2:0][QB-1:0] quo;
  side_t              sd_q [DIVLAT];

  tps_div #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_div (
    .clk (clk),
    .en  (en),
    .mag (mid_q[ROOT_BITS-1].nm),
    .len (len_root),
    .quo (quo)
  );

  // Stage 11: signed normal. Stage 12: dot products. Stage 13: dot sum.
  side_t                 sb11, sb12, sb13;
  logic signed [QB-1:0]  nrm11 [3];
  logic signed [QB-1:0]  nrm12 [3];
  logic signed [QB-1:0]  nrm13 [3];
  logic signed [DPW-1:0] dp12  [3];
  logic signed [DOTW-1:0] dot13;

  // Output stage: round half up, negate and saturate the offset.
  logic signed [DOTW-1:0] off_next;

  always_comb begin
    logic signed [DOTW-1:0] rnd;
    logic signed [DOTW-1:0] shv;
    rnd      = dot13 + ROUND_HALF;
    shv      = rnd >>> NORMAL_FRAC_BITS;
    off_next = -shv;
    if (off_next < OFF_MIN) off_next = OFF_MIN;
    if (off_next > OFF_MAX) off_next = OFF_MAX;
  end

  // Valid bits travel with the data and freeze with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      v12 <= 1'b0;
      v13 <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < ROOT_BITS; k++) mid_v[k] <= 1'b0;
      for (int k = 0; k < DIVLAT; k++) sd_v[k] <= 1'b0;
    end else if (en) begin
      v1  <= in_valid;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
      mid_v[0] <= v10;
      for (int k = 1; k < ROOT_BITS; k++) mid_v[k] <= mid_v[k-1];
      sd_v[0] <= mid_v[ROOT_BITS-1];
      for (int k = 1; k < DIVLAT; k++) sd_v[k] <= sd_v[k-1];
      v11 <= sd_v[DIVLAT-1];
      v12 <= v11;
      v13 <= v12;
      out_valid <= v13;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (en) begin
      sb1 <= side1_next;
      e1x <= edge_diff(bx, ax);
      e1y <= edge_diff(by, ay);
      e1z <= edge_diff(bz, az);
      e2x <= edge_diff(cx, bx);
      e2y <= edge_diff(cy, by);
      e2z <= edge_diff(cz, bz);

      sb2  <= sb1;
      p_yz <= e1y * e2z;
      p_zy <= e1z * e2y;
      p_zx <= e1z * e2x;
      p_xz <= e1x * e2z;
      p_xy <= e1x * e2y;
      p_yx <= e1y * e2x;

      sb3 <= sb2;
      crx <= {p_yz[PW-1], p_yz} - {p_zy[PW-1], p_zy};
      cry <= {p_zx[PW-1], p_zx} - {p_xz[PW-1], p_xz};
      crz <= {p_xy[PW-1], p_xy} - {p_yx[PW-1], p_yx};

      sb4 <= side4_next;
      mg4 <= mg_next;

      sb5 <= sb4;
      mg5 <= mg4;
      mx5 <= mx_next;

      sb6  <= sb5;
      mg6  <= mg5;
      gnz6 <= gnz_next;
      glz6 <= glz_next;

      sb7 <= sb6;
      mg7 <= mg6;
      lz7 <= lz_next;

      sb8 <= sb7;
      nm8 <= nm_next;

      sb9 <= sb8;
      nm9 <= nm8;
      for (int i = 0; i < 3; i++) sq9[i] <= nm8[i] * nm8[i];

      mid10.sb <= sb9;
      mid10.nm <= nm9;
      sum10    <= SUM_BITS'(sq9[0]) + SUM_BITS'(sq9[1]) + SUM_BITS'(sq9[2]);

      mid_q[0] <= mid10;
      for (int k = 1; k < ROOT_BITS; k++) mid_q[k] <= mid_q[k-1];
      sd_q[0] <= mid_q[ROOT_BITS-1].sb;
      for (int k = 1; k < DIVLAT; k++) sd_q[k] <= sd_q[k-1];

      sb11 <= sd_q[DIVLAT-1];
      for (int i = 0; i < 3; i++) begin
        nrm11[i] <= sd_q[DIVLAT-1].sgn[i] ? -$signed(quo[i]) : $signed(quo[i]);
      end

      sb12 <= sb11;
      for (int i = 0; i < 3; i++) nrm12[i] <= nrm11[i];
      dp12[0] <= nrm11[0] * sb11.ax;
      dp12[1] <= nrm11[1] * sb11.ay;
      dp12[2] <= nrm11[2] * sb11.az;

      sb13 <= sb12;
      for (int i = 0; i < 3; i++) nrm13[i] <= nrm12[i];
      dot13 <= DOTW'(dp12[0]) + DOTW'(dp12[1]) + DOTW'(dp12[2]);

      // A degenerate triangle clears every field but its flag.
      degenerate <= sb13.degen;
      if (sb13.degen) begin
        norm_x       <= '0;
        norm_y       <= '0;
        norm_z       <= '0;
        plane_offset <= '0;
        lowest_y     <= '0;
        highest_y    <= '0;
      end else begin
        norm_x       <= 32'(nrm13[0]);
        norm_y       <= 32'(nrm13[1]);
        norm_z       <= 32'(nrm13[2]);
        plane_offset <= off_next[COORD_BITS:0];
        lowest_y     <= sb13.ymin;
        highest_y    <= sb13.ymax;
      end
    end
  end

endmodule

>>> rtl/tps_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module tps_isqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [tps_pkg::SUM_BITS-1:0]   radicand,
  output logic [tps_pkg::ROOT_BITS-1:0]  root
);
  import tps_pkg::*;

  localparam int RW = ROOT_BITS + 2;

  logic [RW-1:0]        rem_q     [ROOT_BITS];
  logic [RW-1:0]        rem_next  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_q    [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_next [ROOT_BITS];
  logic [SUM_BITS-1:0]  rad_q     [ROOT_BITS];
  logic [SUM_BITS-1:0]  rad_next  [ROOT_BITS];

  always_comb begin
    logic [RW-1:0]        rem_in;
    logic [RW-1:0]        rem_try;
    logic [RW-1:0]        trial;
    logic [ROOT_BITS-1:0] root_in;
    logic [SUM_BITS-1:0]  rad_in;
    for (int k = 0; k < ROOT_BITS; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = radicand;
      end else begin
        rem_in  = rem_q[k-1];
        root_in = root_q[k-1];
        rad_in  = rad_q[k-1];
      end
      // Bring down the next two radicand bits and try root*4+1.
      rem_try = {rem_in[RW-3:0], rad_in[SUM_BITS-1 -: 2]};
      trial   = {root_in, 2'b01};
      if (rem_try >= trial) begin
        rem_next[k]  = rem_try - trial;
        root_next[k] = {root_in[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_next[k]  = rem_try;
        root_next[k] = {root_in[ROOT_BITS-2:0], 1'b0};
      end
      rad_next[k] = rad_in << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q  <= rem_next;
      root_q <= root_next;
      rad_q  <= rad_next;
    end
  end

  assign root = root_q[ROOT_BITS-1];

endmodule

>>> rtl/tps_div.sv
// ----------------------------------------------------------------------------
// Pipelined normal divider
// Three lanes of restoring division giving round(mag * 2^F / len).
// ----------------------------------------------------------------------------
module tps_div #(
  parameter int NORMAL_FRAC_BITS = 30
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [2:0][tps_pkg::MAG_BITS-1:0]   mag,
  input  logic [tps_pkg::ROOT_BITS-1:0]       len,
  output logic [2:0][NORMAL_FRAC_BITS+1:0]    quo
);
  import tps_pkg::*;

  localparam int QB   = NORMAL_FRAC_BITS + 2;
  localparam int NUMW = MAG_BITS + NORMAL_FRAC_BITS + 1;

  logic [ROOT_BITS-1:0] rem_q     [QB+1][3];
  logic [ROOT_BITS-1:0] rem_next  [QB+1][3];
  logic [QB-1:0]        low_q     [QB+1][3];
  logic [QB-1:0]        low_next  [QB+1][3];
  logic [QB-1:0]        quo_q     [QB+1][3];
  logic [QB-1:0]        quo_next  [QB+1][3];
  logic [ROOT_BITS-1:0] len_q     [QB+1];
  logic [ROOT_BITS-1:0] len_next  [QB+1];

  always_comb begin
    logic [NUMW-1:0]    num;
    logic [ROOT_BITS:0] r2;
    logic [ROOT_BITS:0] dv;
    // First stage forms the rounded numerator; its upper part is below len.
    for (int i = 0; i < 3; i++) begin
      num = NUMW'({mag[i], {NORMAL_FRAC_BITS{1'b0}}}) + NUMW'(len >> 1);
      rem_next[0][i] = ROOT_BITS'(num[NUMW-1:QB]);
      low_next[0][i] = num[QB-1:0];
      quo_next[0][i] = '0;
    end
    len_next[0] = len;
    for (int k = 1; k <= QB; k++) begin
      len_next[k] = len_q[k-1];
      dv = {1'b0, len_q[k-1]};
      for (int i = 0; i < 3; i++) begin
        r2 = {rem_q[k-1][i], low_q[k-1][i][QB-1]};
        if (r2 >= dv) begin
          rem_next[k][i] = ROOT_BITS'(r2 - dv);
          quo_next[k][i] = {quo_q[k-1][i][QB-2:0], 1'b1};
        end else begin
          rem_next[k][i] = ROOT_BITS'(r2);
          quo_next[k][i] = {quo_q[k-1][i][QB-2:0], 1'b0};
        end
        low_next[k][i] = low_q[k-1][i] << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q <= rem_next;
      low_q <= low_next;
      quo_q <= quo_next;
      len_q <= len_next;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo[i] = quo_q[QB][i];
    end
  end

endmodule

>>> rtl/tps_check.sv
// ----------------------------------------------------------------------------
// Triangle plane setup checker
// Port-level properties of the plane setup block, bound to its top level.
// ----------------------------------------------------------------------------
`include "triangle_plane_setup_assert.svh"

module tps_check #(
  parameter int COORD_BITS       = 24,
  parameter int NORMAL_FRAC_BITS = 30
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [31:0]           norm_x,
  input logic signed [31:0]           norm_y,
  input logic signed [31:0]           norm_z,
  input logic signed [COORD_BITS:0]   plane_offset,
  input logic signed [COORD_BITS-1:0] lowest_y,
  input logic signed [COORD_BITS-1:0] highest_y,
  input logic                         degenerate
);

  // All three normal components are zero.
  logic norm_zero;
  // The offset and both y bounds are zero.
  logic rest_zero;

  assign norm_zero = (norm_x == '0) && (norm_y == '0) && (norm_z == '0);
  assign rest_zero = (plane_offset == '0) && (lowest_y == '0) && (highest_y == '0);

  // A held output word stays offered.
  `TPS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // The input side is held back exactly while the output word is held.
  `TPS_ASSERT_IMPLY(a_in_stall, clk, rst, 1'b1, in_stall == (out_valid && out_stall))

  // A degenerate result carries nothing but its flag.
  `TPS_ASSERT_IMPLY(a_degen_zero, clk, rst, out_valid && degenerate, norm_zero && rest_zero)

  // The y bounds of a real triangle are ordered.
  `TPS_ASSERT_IMPLY(a_y_order, clk, rst, out_valid && !degenerate, lowest_y <= highest_y)

  // A real triangle always has a nonzero normal.
  `TPS_ASSERT_IMPLY(a_norm_nz, clk, rst, out_valid && !degenerate, !norm_zero)

endmodule

bind triangle_plane_setup tps_check #(
  .COORD_BITS       (COORD_BITS),
  .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_check (.*);
